// ===== design/srec_pkg.sv =====
package srec_pkg;

  // Register map of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_APP_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APP_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_END   = 2'd3;

  // Characters the parser looks for
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_SKIP    = 3'd1,
    PH_TYPE    = 3'd2,
    PH_COUNT   = 3'd3,
    PH_ADDR_HI = 3'd4,
    PH_ADDR_LO = 3'd5,
    PH_DATA    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    EV_APP   = 2'd0,
    EV_BOOT  = 2'd1,
    EV_RANGE = 2'd2,
    EV_TYPE  = 2'd3
  } ev_kind_t;

  // One result transaction as it leaves the parser
  typedef struct packed {
    logic        valid;
    ev_kind_t    kind;
    logic [15:0] offset;
    logic [7:0]  data;
  } srec_evt_t;

endpackage

// ===== design/srec_if.sv =====
interface srec_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface srec_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [15:0] region_offset;
  logic [7:0]  data_byte;

  modport source (output valid, output event_kind, output region_offset, output data_byte,
                  input ready);
  modport sink (input valid, input event_kind, input region_offset, input data_byte,
                output ready);
endinterface

// ===== design/srec_parse.sv =====
module srec_parse (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc,
  input  logic [7:0]                      char_in,
  input  logic                            cfg_we,
  input  logic [srec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_wdata,
  output srec_pkg::srec_evt_t             evt
);
  import srec_pkg::*;

  // Configuration registers
  logic [15:0] app_start_r, app_end_r, boot_start_r, boot_end_r;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  hi_nib_r, hi_nib_nxt;
  logic        pend_r, pend_nxt;
  logic        bad_r, bad_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [16:0] addr_r, addr_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        boot_r, boot_nxt;
  logic        halted_r, halted_nxt;

  // Decode helpers
  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [7:0]  pair_byte;
  logic [16:0] lo_addr;
  logic [15:0] reg_start, reg_end;
  logic [7:0]  left_dec;
  logic        in_app, in_boot;

  // Decode one hex digit; anything else is flagged and reads as zero
  always_comb begin
    dig_ok  = 1'b1;
    dig_val = 4'd0;
    if (char_in >= CH_ZERO && char_in <= CH_NINE) begin
      dig_val = 4'(char_in - CH_ZERO);
    end else if (char_in >= CH_UA && char_in <= CH_UF) begin
      dig_val = 4'(char_in - CH_UA + 8'd10);
    end else if (char_in >= CH_LA && char_in <= CH_LF) begin
      dig_val = 4'(char_in - CH_LA + 8'd10);
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign pair_byte = (bad_r || !dig_ok) ? 8'd0 : {hi_nib_r, dig_val};
  assign lo_addr   = {addr_r[16:8], pair_byte};
  assign in_app    = (lo_addr >= {1'b0, app_start_r}) && (lo_addr <= {1'b0, app_end_r});
  assign in_boot   = (lo_addr >= {1'b0, boot_start_r}) && (lo_addr <= {1'b0, boot_end_r});
  assign reg_start = boot_r ? boot_start_r : app_start_r;
  assign reg_end   = boot_r ? boot_end_r : app_end_r;
  assign left_dec  = left_r - 8'd1;

  // Next parser state and the result of this character
  always_comb begin
    phase_nxt  = phase_r;
    hi_nib_nxt = hi_nib_r;
    pend_nxt   = pend_r;
    bad_nxt    = bad_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    left_nxt   = left_r;
    boot_nxt   = boot_r;
    halted_nxt = halted_r;
    evt        = '{valid: 1'b0, kind: EV_APP, offset: 16'd0, data: 8'd0};

    if (acc && !halted_r) begin
      if (char_in == CH_NL) begin
        if (phase_r == PH_TYPE) begin
          halted_nxt = 1'b1;
          evt        = '{valid: 1'b1, kind: EV_TYPE, offset: 16'd0, data: 8'd0};
        end else begin
          phase_nxt = PH_START;
          pend_nxt  = 1'b0;
          bad_nxt   = 1'b0;
        end
      end else begin
        unique case (phase_r)
          PH_START: begin
            phase_nxt = (char_in == CH_S) ? PH_TYPE : PH_SKIP;
          end
          PH_TYPE: begin
            if (char_in == CH_ONE) begin
              phase_nxt = PH_COUNT;
              pend_nxt  = 1'b0;
              bad_nxt   = 1'b0;
            end else if (char_in == CH_ZERO || char_in == CH_EIGHT || char_in == CH_NINE) begin
              phase_nxt = PH_SKIP;
            end else begin
              halted_nxt = 1'b1;
              evt        = '{valid: 1'b1, kind: EV_TYPE, offset: 16'd0, data: 8'd0};
            end
          end
          PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_DATA: begin
            if (!pend_r) begin
              // hold the first digit of the pair
              hi_nib_nxt = dig_val;
              bad_nxt    = !dig_ok;
              pend_nxt   = 1'b1;
            end else begin
              pend_nxt = 1'b0;
              bad_nxt  = 1'b0;
              priority case (phase_r)
                PH_COUNT: begin
                  count_nxt = pair_byte;
                  phase_nxt = PH_ADDR_HI;
                end
                PH_ADDR_HI: begin
                  addr_nxt  = {1'b0, pair_byte, 8'd0};
                  phase_nxt = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                  // pick the region; application wins on overlap
                  addr_nxt = lo_addr;
                  if (in_app || in_boot) begin
                    boot_nxt  = !in_app;
                    left_nxt  = (count_r >= 8'd3) ? count_r - 8'd3 : 8'd0;
                    phase_nxt = (count_r > 8'd3) ? PH_DATA : PH_SKIP;
                  end else begin
                    halted_nxt = 1'b1;
                    evt        = '{valid: 1'b1, kind: EV_RANGE, offset: lo_addr[15:0],
                                   data: 8'd0};
                  end
                end
                default: begin
                  // data byte: write at offset, or fault past the region end
                  if (addr_r > {1'b0, reg_end}) begin
                    halted_nxt = 1'b1;
                    evt        = '{valid: 1'b1, kind: EV_RANGE, offset: addr_r[15:0],
                                   data: 8'd0};
                  end else begin
                    evt      = '{valid: 1'b1, kind: (boot_r ? EV_BOOT : EV_APP),
                                 offset: addr_r[15:0] - reg_start, data: pair_byte};
                    addr_nxt = addr_r + 17'd1;
                    left_nxt = left_dec;
                    if (left_dec == 8'd0) begin
                      phase_nxt = PH_SKIP;
                    end
                  end
                end
              endcase
            end
          end
          default: begin
            // skip to end of line
          end
        endcase
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_start_r  <= 16'h0000;
      app_end_r    <= 16'hFFFF;
      boot_start_r <= 16'h0000;
      boot_end_r   <= 16'h0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_APP_START:  app_start_r  <= cfg_wdata;
        CFG_APP_END:    app_end_r    <= cfg_wdata;
        CFG_BOOT_START: boot_start_r <= cfg_wdata;
        CFG_BOOT_END:   boot_end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      hi_nib_r <= 4'd0;
      pend_r   <= 1'b0;
      bad_r    <= 1'b0;
      count_r  <= 8'd0;
      addr_r   <= 17'd0;
      left_r   <= 8'd0;
      boot_r   <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hi_nib_r <= hi_nib_nxt;
      pend_r   <= pend_nxt;
      bad_r    <= bad_nxt;
      count_r  <= count_nxt;
      addr_r   <= addr_nxt;
      left_r   <= left_nxt;
      boot_r   <= boot_nxt;
      halted_r <= halted_nxt;
    end
  end

  // A halted parser produces nothing
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !evt.valid)
    else $error("event produced while halted");

  // Every error transaction halts the parser
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid && (evt.kind == EV_RANGE || evt.kind == EV_TYPE) |=> halted_r)
    else $error("error event did not halt the parser");

  // Data phase always has bytes outstanding
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (left_r != 8'd0))
    else $error("data phase with no bytes left");

endmodule

// ===== design/srecord_s1_loader.sv =====
// S1 record loader.
// in_ch carries the S-record text, one character per transaction; a newline
// ends every line. out_ev carries one transaction per data byte written
// (application or boot region, offset from region start) and one for an
// address range error or an unknown record type. After an error the block
// swallows all further characters and emits nothing until reset.
// The cfg_ port writes the four region bounds, index 0 to 3; write them only
// while no transaction is in flight.
// Results: a character accepted at edge N shows its result on out_ev from
// the cycle after edge N when no earlier result waits; otherwise the result
// queues behind the waiting one. Throughput: one character per cycle; the
// parser itself never holds a character back, so nothing limits the rate but
// the two-entry result buffer.
// Stall: results queue in a two-entry buffer; in_ch.ready drops only while
// both entries are full, so a character is taken while one result waits.
// Reset (rst_n low, synchronous): parser returns to line start, the buffer
// empties, region bounds go to app 0..0xFFFF and boot 0..0.
module srecord_s1_loader (
  input  logic                            clk,
  input  logic                            rst_n,
  srec_char_if.sink                       in_ch,
  srec_evt_if.source                      out_ev,
  input  logic                            cfg_we,
  input  logic [srec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_wdata
);
  import srec_pkg::*;

  srec_evt_t evt;
  logic      acc, pop;

  // Two-entry result buffer: slot 0 drives the output
  logic      v0_r, v0_nxt, v1_r, v1_nxt;
  srec_evt_t e0_r, e0_nxt, e1_r, e1_nxt;

  assign in_ch.ready = !v1_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign pop         = v0_r && out_ev.ready;

  srec_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .char_in   (in_ch.char_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .evt       (evt)
  );

  // Advance the buffer on pop, append on push
  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    e0_nxt = e0_r;
    e1_nxt = e1_r;
    if (pop) begin
      v0_nxt = v1_r;
      v1_nxt = 1'b0;
      e0_nxt = e1_r;
    end
    if (evt.valid) begin
      if (!v0_nxt) begin
        v0_nxt = 1'b1;
        e0_nxt = evt;
      end else begin
        v1_nxt = 1'b1;
        e1_nxt = evt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign out_ev.valid         = v0_r;
  assign out_ev.event_kind    = e0_r.kind;
  assign out_ev.region_offset = e0_r.offset;
  assign out_ev.data_byte     = e0_r.data;

  // Buffer fills from slot 0
  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> v0_r)
    else $error("second slot valid with head empty");

  // A new result never arrives into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid |-> !v1_r)
    else $error("result pushed into full buffer");

  // A result pushed into an empty buffer shows at the output next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid && !v0_r |=> v0_r && (e0_r == $past(evt)))
    else $error("pushed result not at buffer head");

endmodule
